>>> rtl/port_latch_nibble_ram_scan_io_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers for the port latch I/O checker.
// ----------------------------------------------------------------------------
`ifndef PORT_LATCH_NIBBLE_RAM_SCAN_IO_UNIT_ASSERT_SVH
`define PORT_LATCH_NIBBLE_RAM_SCAN_IO_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PLNRS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("port latch io: implication failed");

// next-cycle implication, sampled on clk, off during reset
`define PLNRS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("port latch io: next-cycle check failed");

`endif

>>> rtl/plnrs_pkg.sv
// ----------------------------------------------------------------------------
// plnrs_pkg
// Port codes, register indexes and the row select table.
// ----------------------------------------------------------------------------
package plnrs_pkg;

	localparam int RAM_NIBBLES_DEF = 4096;

	// port numbers
	localparam logic [3:0] PORT_A = 4'd0;
	localparam logic [3:0] PORT_B = 4'd1;
	localparam logic [3:0] PORT_C = 4'd2;
	localparam logic [3:0] PORT_D = 4'd3;
	localparam logic [3:0] PORT_E = 4'd4;
	localparam logic [3:0] PORT_F = 4'd5;
	localparam logic [3:0] PORT_G = 4'd6;
	localparam logic [3:0] PORT_H = 4'd7;
	localparam logic [3:0] PORT_I = 4'd8;

	// action codes
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	// config register indexes
	localparam logic [1:0] CFG_CHIP_EN_LVL  = 2'd0;
	localparam logic [1:0] CFG_WRITE_EN_LVL = 2'd1;
	localparam logic [1:0] CFG_LIVE_CLK_EN  = 2'd2;

	// row code that selects the status group
	localparam logic [2:0] ROW_STATUS = 3'd4;

	// latch H low nibble -> scan row
	localparam logic [2:0] ROW_TABLE [16] = '{
		3'd0, 3'd1, 3'd0, 3'd2, 3'd0, 3'd1, 3'd0, 3'd3,
		3'd0, 3'd1, 3'd0, 3'd2, 3'd0, 3'd1, 3'd0, 3'd4
	};

endpackage

>>> rtl/plnrs_ram.sv
// ----------------------------------------------------------------------------
// plnrs_ram
// Nibble RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module plnrs_ram
	import plnrs_pkg::*;
#(
	parameter int DEPTH = RAM_NIBBLES_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [3:0]               wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [3:0]               rdata
);

	logic [3:0] mem_q [DEPTH];

	// read-before-write on a shared address
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/port_latch_nibble_ram_scan_io_unit.sv
// An accepted item goes to out_valid through stage 1 and the result register.
// Throughput: one item per cycle when out_stall and the clearing pass allow;
//   the RAM read is issued at accept and the write-back as it leaves stage 1.
// Reset: arst_n clears latches, config, dirty flag and both stages, then a
//   clearing pass zeroes all RAM_NIBBLES (4096) nibbles, one nibble a cycle,
//   with in_stall held high. Config writes are taken during the pass.
// ----------------------------------------------------------------------------
// port_latch_nibble_ram_scan_io_unit
// Port latches C-I, a 4096-nibble RAM committed from latch C, and the
// switch-matrix / status read path for a 4-bit controller.
// ----------------------------------------------------------------------------
module port_latch_nibble_ram_scan_io_unit
	import plnrs_pkg::*;
#(
	parameter int RAM_NIBBLES = RAM_NIBBLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// config
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic        cfg_data,
	// item in
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [3:0]  port,
	input  logic [3:0]  write_data,
	input  logic [35:0] switch_lines,
	input  logic        live_clock_level,
	// item out
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  read_data,
	output logic        echo_valid,
	output logic [3:0]  echo_port,
	output logic [3:0]  echo_data,
	output logic        ram_dirty
);

	localparam int AW = $clog2(RAM_NIBBLES);

	// ---------------- config registers
	logic ce_lvl_q, we_lvl_q, lclk_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ce_lvl_q  <= 1'b0;
			we_lvl_q  <= 1'b0;
			lclk_en_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CHIP_EN_LVL:  ce_lvl_q  <= cfg_data;
				CFG_WRITE_EN_LVL: we_lvl_q  <= cfg_data;
				CFG_LIVE_CLK_EN:  lclk_en_q <= cfg_data;
				default: ;  // index past the list: ignored
			endcase
		end
	end

	// ---------------- RAM clearing pass after reset
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(RAM_NIBBLES - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// ---------------- handshakes
	logic valid_s1, out_valid_q;
	logic s1_adv, acc;

	// stage 1 moves on when the result register is free or being drained
	assign s1_adv   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = clr_busy_q || (valid_s1 && !s1_adv);
	assign acc      = in_valid && !in_stall;

	// ---------------- port latches, updated as the item is accepted
	// latch G feeds nothing in this block; a G write is only echoed
	logic [3:0] latch_c_q, latch_d_q, latch_e_q, latch_f_q;
	logic [3:0] latch_h_q, latch_i_q;
	logic [3:0] nxt_c, nxt_d, nxt_e, nxt_f, nxt_i;
	logic       is_wr, port_ci, port_commit;

	assign is_wr   = (action == ACT_WRITE);
	// writes C..I are the ones that get echoed; all but G also load a latch
	assign port_ci = (port >= PORT_C) && (port <= PORT_I);
	// H loads and G is echoed, both without a RAM commit
	assign port_commit = port_ci && (port != PORT_G) && (port != PORT_H);

	assign nxt_c = (is_wr && port == PORT_C) ? write_data : latch_c_q;
	assign nxt_d = (is_wr && port == PORT_D) ? write_data : latch_d_q;
	assign nxt_e = (is_wr && port == PORT_E) ? write_data : latch_e_q;
	assign nxt_f = (is_wr && port == PORT_F) ? write_data : latch_f_q;
	assign nxt_i = (is_wr && port == PORT_I) ? write_data : latch_i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_c_q <= '0;
			latch_d_q <= '0;
			latch_e_q <= '0;
			latch_f_q <= '0;
			latch_h_q <= '0;
			latch_i_q <= '0;
		end else if (acc) begin
			latch_c_q <= nxt_c;
			latch_d_q <= nxt_d;
			latch_e_q <= nxt_e;
			latch_f_q <= nxt_f;
			latch_i_q <= nxt_i;
			if (is_wr && port == PORT_H) begin
				latch_h_q <= write_data;
			end
		end
	end

	// ---------------- RAM control decoded from the post-write latches
	logic          chip_on, write_on;
	logic [11:0]   full_addr;
	logic [AW-1:0] nxt_addr;
	logic          nxt_commit, nxt_rdc;

	assign chip_on    = (nxt_i[1] == ce_lvl_q);
	assign write_on   = (nxt_i[0] == we_lvl_q);
	assign full_addr  = {nxt_e, nxt_f, nxt_d};
	assign nxt_addr   = full_addr[AW-1:0];
	assign nxt_commit = is_wr && port_commit && chip_on && write_on;
	assign nxt_rdc    = !is_wr && (port == PORT_C) && chip_on && !write_on;

	// ---------------- switch matrix / status read, done at accept
	logic [2:0] row;
	logic [3:0] stat_nib, row_a, row_b, ab_nib;

	assign row = ROW_TABLE[latch_h_q];
	// live clock replaces status bit 3 when enabled
	assign stat_nib = lclk_en_q ? {live_clock_level, switch_lines[34:32]}
	                            : switch_lines[35:32];

	always_comb begin
		case (row)
			3'd0:    begin row_a = switch_lines[19:16]; row_b = switch_lines[3:0];   end
			3'd1:    begin row_a = switch_lines[23:20]; row_b = switch_lines[7:4];   end
			3'd2:    begin row_a = switch_lines[27:24]; row_b = switch_lines[11:8];  end
			3'd3:    begin row_a = switch_lines[31:28]; row_b = switch_lines[15:12]; end
			default: begin row_a = stat_nib;            row_b = 4'd0;                end
		endcase
		ab_nib = 4'd0;
		if (!is_wr && port == PORT_A) begin
			ab_nib = row_a;
		end else if (!is_wr && port == PORT_B) begin
			ab_nib = row_b;
		end
	end

	// ---------------- stage 1 registers
	logic          commit_s1, rdc_s1, fwd_s1, ev_s1;
	logic [3:0]    c_s1, fwd_data_s1, ab_s1, ep_s1, ed_s1;
	logic [AW-1:0] addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			commit_s1   <= nxt_commit;
			rdc_s1      <= nxt_rdc;
			c_s1        <= nxt_c;
			addr_s1     <= nxt_addr;
			// the item leaving stage 1 writes the RAM on this same edge, so its
			// nibble is not yet in the read data: forward it
			fwd_s1      <= valid_s1 && commit_s1 && (addr_s1 == nxt_addr);
			fwd_data_s1 <= c_s1;
			ab_s1       <= ab_nib;
			ev_s1       <= is_wr && port_ci;
			ep_s1       <= (is_wr && port_ci) ? port : 4'd0;
			ed_s1       <= (is_wr && port_ci) ? write_data : 4'd0;
		end
	end

	// ---------------- nibble RAM
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [3:0]    ram_wdata, ram_rdata;

	assign ram_we    = clr_busy_q || (s1_adv && commit_s1);
	assign ram_waddr = clr_busy_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clr_busy_q ? 4'd0 : c_s1;

	plnrs_ram #(
		.DEPTH(RAM_NIBBLES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (acc),
		.raddr(nxt_addr),
		.rdata(ram_rdata)
	);

	// ---------------- stage 1 logic: compare for dirty, pick read data
	logic [3:0] old_nib;
	logic       dirty_q, dirty_nxt;

	assign old_nib   = fwd_s1 ? fwd_data_s1 : ram_rdata;
	assign dirty_nxt = dirty_q || (commit_s1 && (old_nib != c_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q <= 1'b0;
		end else if (s1_adv) begin
			dirty_q <= dirty_nxt;
		end
	end

	// ---------------- result register
	logic [3:0] rd_q, ep_q, ed_q;
	logic       ev_q, rdirty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rd_q     <= rdc_s1 ? old_nib : ab_s1;
			ev_q     <= ev_s1;
			ep_q     <= ep_s1;
			ed_q     <= ed_s1;
			rdirty_q <= dirty_nxt;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_data  = rd_q;
	assign echo_valid = ev_q;
	assign echo_port  = ep_q;
	assign echo_data  = ed_q;
	assign ram_dirty  = rdirty_q;

endmodule

>>> rtl/plnrs_chk.sv
// ----------------------------------------------------------------------------
// plnrs_chk
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "port_latch_nibble_ram_scan_io_unit_assert.svh"

module plnrs_chk
	import plnrs_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [3:0] read_data,
	input logic       echo_valid,
	input logic [3:0] echo_port,
	input logic [3:0] echo_data,
	input logic       ram_dirty
);

	// stalled result holds
	`PLNRS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(read_data) && $stable(echo_port))
	// writes return no read data
	`PLNRS_ASSERT_IMP(a_wr_no_rd, out_valid && echo_valid, read_data == 4'd0)
	// no echo fields without an echo
	`PLNRS_ASSERT_IMP(a_echo_zero, out_valid && !echo_valid, echo_port == 4'd0 && echo_data == 4'd0)
	// echoed ports are the latched ones only
	`PLNRS_ASSERT_IMP(a_echo_port, out_valid && echo_valid, echo_port >= PORT_C && echo_port <= PORT_I)
	// dirty is sticky
	`PLNRS_ASSERT_NXT(a_dirty_sticky, out_valid && ram_dirty, ram_dirty)

endmodule

bind port_latch_nibble_ram_scan_io_unit plnrs_chk u_chk (.*);

>>> bench/tb_port_latch_nibble_ram_scan_io_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_port_latch_nibble_ram_scan_io_unit
// Self-checking bench for the port latch / nibble RAM / scan I/O unit. A
// behavioral shadow of latches C-I, the 4096-nibble RAM and the dirty flag
// predicts every result. Directed port accesses come first, then random
// RAM store/load sequences, scan reads and noise under three idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_port_latch_nibble_ram_scan_io_unit;
	import plnrs_pkg::*;

	// ports past I: writes there must be dropped
	localparam logic [3:0] PORT_PAST_I = 4'd9;
	localparam logic [3:0] PORT_TOP    = 4'd15;

	typedef struct packed {
		logic [3:0] read_data;
		logic       echo_valid;
		logic [3:0] echo_port;
		logic [3:0] echo_data;
		logic       ram_dirty;
	} port_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic        cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        action;
	logic [3:0]  port;
	logic [3:0]  write_data;
	logic [35:0] switch_lines;
	logic        live_clock_level;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  read_data;
	logic        echo_valid;
	logic [3:0]  echo_port;
	logic [3:0]  echo_data;
	logic        ram_dirty;

	// shadow of the block: latches, RAM, dirty flag and config levels
	// (latch G has no visible effect, so it is not shadowed)
	logic [3:0] lat_c, lat_d, lat_e, lat_f, lat_h, lat_i;
	logic [3:0] shadow_ram [RAM_NIBBLES_DEF];
	logic       shadow_dirty;
	logic       ce_level, we_level, clk_live_en;

	// expected results, oldest first
	port_result_t pending_port_results [$];

	int send_idle_pct;
	int recv_stall_pct;
	int items_effective;
	int results_checked;
	int ram_changes;
	int mismatches;

	port_latch_nibble_ram_scan_io_unit i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.action           (action),
		.port             (port),
		.write_data       (write_data),
		.switch_lines     (switch_lines),
		.live_clock_level (live_clock_level),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.read_data        (read_data),
		.echo_valid       (echo_valid),
		.echo_port        (echo_port),
		.echo_data        (echo_data),
		.ram_dirty        (ram_dirty)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// generous cap: reset clearing pass plus a slow, heavily stalled run
	initial begin
		#5_000_000;
		$display("port_latch_nibble_ram_scan_io_unit regression: fail");
		$finish;
	end

	// ------------------------------------------------------------------
	// Shadow model
	// ------------------------------------------------------------------

	// RAM chip select and write strobe, both taken from latch I
	function automatic logic ram_selected();
		return lat_i[1] == ce_level;
	endfunction

	function automatic logic ram_writing();
		return lat_i[0] == we_level;
	endfunction

	function automatic logic [11:0] ram_addr();
		return {lat_e, lat_f, lat_d};
	endfunction

	// scan row = number of trailing ones in latch H; four ones means status
	function automatic logic [2:0] scan_row(input logic [3:0] h);
		logic [2:0] n;
		n = 3'd0;
		for (int k = 0; k < 4; k++) begin
			if (h[k] && n == k)
				n++;
		end
		return n;
	endfunction

	function automatic logic is_latch_port(input logic [3:0] p);
		return p >= PORT_C && p <= PORT_I;
	endfunction

	// latch C goes to RAM while select and strobe are both active;
	// only an actual change of the nibble marks the RAM dirty
	task automatic store_latch_c();
		if (ram_writing() && ram_selected() && shadow_ram[ram_addr()] != lat_c) begin
			shadow_ram[ram_addr()] = lat_c;
			shadow_dirty = 1'b1;
			ram_changes++;
		end
	endtask

	// applies one accepted access to the shadow and queues its result
	task automatic compute_port_access(input logic act, input logic [3:0] prt,
			input logic [3:0] data, input logic [35:0] lines, input logic lvl);
		port_result_t r;
		logic [2:0] row;
		r = '0;
		if (act == ACT_WRITE) begin
			if (is_latch_port(prt)) begin
				case (prt)
					PORT_C: lat_c = data;
					PORT_D: lat_d = data;
					PORT_E: lat_e = data;
					PORT_F: lat_f = data;
					PORT_G: ;  // nothing reads G back
					PORT_H: lat_h = data;
					default: lat_i = data;
				endcase
				// G and H never touch the RAM
				if (prt != PORT_G && prt != PORT_H)
					store_latch_c();
				r.echo_valid = 1'b1;
				r.echo_port = prt;
				r.echo_data = data;
			end
		end else begin
			row = scan_row(lat_h);
			case (prt)
				PORT_A: begin
					if (row != ROW_STATUS) begin
						r.read_data = lines[16 + 4 * row +: 4];
					end else begin
						r.read_data = lines[35:32];
						if (clk_live_en)
							r.read_data[3] = lvl;
					end
				end
				PORT_B: begin
					// status row has nothing to offer on B
					if (row != ROW_STATUS)
						r.read_data = lines[4 * row +: 4];
				end
				PORT_C: begin
					if (ram_selected() && !ram_writing())
						r.read_data = shadow_ram[ram_addr()];
				end
				default: ;
			endcase
		end
		r.ram_dirty = shadow_dirty;
		pending_port_results.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// Drivers: everything changes on the falling edge
	// ------------------------------------------------------------------

	function automatic logic [35:0] rand_lines();
		logic [63:0] raw;
		raw = {$urandom(), $urandom()};
		return raw[35:0];
	endfunction

	// address nibbles mostly from a tiny pool so loads find earlier stores
	function automatic logic [3:0] addr_nibble();
		logic [3:0] v;
		if ($urandom_range(0, 99) < 85)
			v = 4'($urandom_range(0, 1));
		else
			v = 4'($urandom_range(0, 15));
		return v;
	endfunction

	// presents one item, holds it until taken, then predicts it
	task automatic access(input logic act, input logic [3:0] prt, input logic [3:0] data,
			input logic [35:0] lines, input logic lvl);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid         <= 1'b1;
		action           <= act;
		port             <= prt;
		write_data       <= data;
		switch_lines     <= lines;
		live_clock_level <= lvl;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		compute_port_access(act, prt, data, lines, lvl);
		if (act == ACT_READ || is_latch_port(prt))
			items_effective++;
	endtask

	task automatic put_nibble(input logic [3:0] prt, input logic [3:0] data);
		access(ACT_WRITE, prt, data, rand_lines(), 1'($urandom_range(0, 1)));
	endtask

	task automatic port_read(input logic [3:0] prt, input logic [35:0] lines, input logic lvl);
		access(ACT_READ, prt, 4'($urandom_range(0, 15)), lines, lvl);
	endtask

	// drop valid and let every outstanding result come home
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_port_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// config write; only called with the pipe empty
	task automatic write_level_reg(input logic [1:0] idx, input logic val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_CHIP_EN_LVL:  ce_level = val;
			CFG_WRITE_EN_LVL: we_level = val;
			default:          clk_live_en = val;
		endcase
	endtask

	task automatic set_levels(input logic ce, input logic we, input logic live);
		write_level_reg(CFG_CHIP_EN_LVL, ce);
		write_level_reg(CFG_WRITE_EN_LVL, we);
		write_level_reg(CFG_LIVE_CLK_EN, live);
	endtask

	// ------------------------------------------------------------------
	// Result side: random stall, check on every accepted result
	// ------------------------------------------------------------------

	always @(negedge clk) begin
		out_stall <= arst_n && ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin : check_results
		port_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_port_results.size() == 0) begin
				$error("result arrived with nothing pending");
				mismatches++;
			end else begin
				want = pending_port_results.pop_front();
				results_checked++;
				if (read_data !== want.read_data) begin
					$error("read_data: expected %0h, got %0h", want.read_data, read_data);
					mismatches++;
				end
				if (echo_valid !== want.echo_valid) begin
					$error("echo_valid: expected %0h, got %0h", want.echo_valid, echo_valid);
					mismatches++;
				end
				if (echo_port !== want.echo_port) begin
					$error("echo_port: expected %0h, got %0h", want.echo_port, echo_port);
					mismatches++;
				end
				if (echo_data !== want.echo_data) begin
					$error("echo_data: expected %0h, got %0h", want.echo_data, echo_data);
					mismatches++;
				end
				if (ram_dirty !== want.ram_dirty) begin
					$error("ram_dirty: expected %0h, got %0h", want.ram_dirty, ram_dirty);
					mismatches++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// row select through latch H, status group on A and B
	task automatic test_scan_rows();
		put_nibble(PORT_G, 4'hF);
		put_nibble(PORT_H, 4'hF);            // all ones: status group
		port_read(PORT_A, 36'hA_0000_0000, 1'b1);
		port_read(PORT_B, '1, 1'b1);         // status on B reads zero
		put_nibble(PORT_H, 4'h7);            // row 3
		port_read(PORT_A, '1, 1'b0);
		port_read(PORT_B, 36'hF_0FFF_0FFF, 1'b0);
		put_nibble(PORT_H, 4'h1);            // row 1
		port_read(PORT_A, 36'h0_0030_0000, 1'b0);
		put_nibble(PORT_H, 4'h2);            // row 0
		port_read(PORT_B, '0, 1'b1);
	endtask

	// writes to A, B and past I are dropped; reads of D and I give zero
	task automatic test_ignored_ports();
		put_nibble(PORT_A, 4'hF);
		put_nibble(PORT_B, 4'h5);
		put_nibble(PORT_PAST_I, 4'hA);
		put_nibble(PORT_TOP, 4'hF);
		port_read(PORT_D, '1, 1'b1);
		port_read(PORT_I, '1, 1'b1);
	endtask

	// levels are 0 here, so latch I = 0 means select and strobe both active
	task automatic test_ram_commit();
		put_nibble(PORT_C, 4'h0);            // same value: RAM stays clean
		put_nibble(PORT_C, 4'hF);            // real change: dirty goes high
		put_nibble(PORT_I, 4'h1);            // strobe off, still selected
		port_read(PORT_C, '0, 1'b0);
		put_nibble(PORT_D, 4'hF);            // moves address, no store
		port_read(PORT_C, '0, 1'b0);
		put_nibble(PORT_I, 4'h2);            // deselected: C reads zero
		port_read(PORT_C, '1, 1'b1);
	endtask

	// status bit 3 follows the live clock only when enabled
	task automatic test_status_live_clock();
		put_nibble(PORT_H, 4'hF);
		drain_results();
		write_level_reg(CFG_LIVE_CLK_EN, 1'b1);
		port_read(PORT_A, 36'h0_0000_0000, 1'b1);
		port_read(PORT_A, 36'hF_0000_0000, 1'b0);
		drain_results();
	endtask

	// one random phase under fixed levels and idle mix
	task automatic run_random_phase(input int idle_pct, input int stall_pct,
			input logic ce, input logic we, input logic live, input int count);
		int start;
		int pick;
		logic [1:0] top2;
		logic [3:0] prt;
		drain_results();
		set_levels(ce, we, live);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		start = items_effective;
		while (items_effective - start < count) begin
			pick = $urandom_range(0, 99);
			top2 = 2'($urandom_range(0, 3));
			if (pick < 50) begin
				// store: arm strobe + select, set address, load C; often read back
				put_nibble(PORT_I, {top2, ce_level, we_level});
				put_nibble(PORT_D, addr_nibble());
				put_nibble(PORT_E, addr_nibble());
				put_nibble(PORT_F, addr_nibble());
				put_nibble(PORT_C, 4'($urandom_range(0, 15)));
				if ($urandom_range(0, 3) != 0) begin
					put_nibble(PORT_I, {top2, ce_level, ~we_level});
					port_read(PORT_C, rand_lines(), 1'($urandom_range(0, 1)));
				end
			end else if (pick < 60) begin
				// load from a likely-used address
				put_nibble(PORT_I, {top2, ce_level, ~we_level});
				put_nibble(PORT_D, addr_nibble());
				put_nibble(PORT_F, addr_nibble());
				port_read(PORT_C, rand_lines(), 1'($urandom_range(0, 1)));
			end else if (pick < 80) begin
				put_nibble(PORT_H, 4'($urandom_range(0, 15)));
				prt = 4'($urandom_range(0, 1));
				port_read(prt, rand_lines(), 1'($urandom_range(0, 1)));
			end else if (pick < 92) begin
				// anything the fields allow
				prt = 4'($urandom_range(0, 15));
				access(1'($urandom_range(0, 1)), prt, 4'($urandom_range(0, 15)),
					rand_lines(), 1'($urandom_range(0, 1)));
			end else begin
				// broken sequence: arbitrary latch I, then touch C
				put_nibble(PORT_I, 4'($urandom_range(0, 15)));
				if ($urandom_range(0, 1))
					port_read(PORT_C, rand_lines(), 1'($urandom_range(0, 1)));
				else
					put_nibble(PORT_C, 4'($urandom_range(0, 15)));
			end
		end
		drain_results();
	endtask

	task automatic test_random_traffic();
		run_random_phase(38, 73, 1'b1, 1'b1, 1'b1, 140);
		run_random_phase(73, 38, 1'b0, 1'b1, 1'b0, 140);
		run_random_phase(0, 0, 1'b1, 1'b0, 1'b1, 140);
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = CFG_CHIP_EN_LVL;
		cfg_data         = 1'b0;
		in_valid         = 1'b0;
		action           = ACT_WRITE;
		port             = PORT_A;
		write_data       = 4'h0;
		switch_lines     = '0;
		live_clock_level = 1'b0;
		send_idle_pct    = 20;
		recv_stall_pct   = 50;
		items_effective  = 0;
		results_checked  = 0;
		ram_changes      = 0;
		mismatches       = 0;

		// shadow reset state
		{lat_c, lat_d, lat_e, lat_f, lat_h, lat_i} = '0;
		for (int a = 0; a < RAM_NIBBLES_DEF; a++)
			shadow_ram[a] = 4'h0;
		shadow_dirty = 1'b0;
		ce_level     = 1'b0;
		we_level     = 1'b0;
		clk_live_en  = 1'b0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// levels taken during the RAM clearing pass; inputs wait on in_stall
		set_levels(1'b0, 1'b0, 1'b0);

		test_scan_rows();
		test_ignored_ports();
		test_ram_commit();
		test_status_live_clock();
		test_random_traffic();

		repeat (8) @(posedge clk);

		$display("covered %0d port accesses, %0d results checked, %0d RAM nibble changes",
			items_effective, results_checked, ram_changes);
		$display("both enable levels, live clock on and off, three idle/stall mixes");
		if (mismatches == 0)
			$display("port_latch_nibble_ram_scan_io_unit regression: pass");
		else
			$display("port_latch_nibble_ram_scan_io_unit regression: fail");
		$finish;
	end

endmodule

>>> port_latch_nibble_ram_scan_io_unit.f
+incdir+rtl
rtl/plnrs_pkg.sv
rtl/plnrs_ram.sv
rtl/port_latch_nibble_ram_scan_io_unit.sv
rtl/plnrs_chk.sv
bench/tb_port_latch_nibble_ram_scan_io_unit.sv
